// ===== hw/rtl/ipk_pkg.sv =====
// Shared types, codes and constants of the iambic paddle keyer.
// No dependencies; every other keyer file but ipk_if imports this package.
`default_nettype none

package ipk_pkg;

    // speed register limits and reset value
    localparam logic [5:0] WPM_MIN   = 6'd5;
    localparam logic [5:0] WPM_MAX   = 6'd60;
    localparam logic [5:0] WPM_RESET = 6'd20;

    // register width, index width and register indexes
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WPM    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_B = 1'd1;

    // tick counter
    localparam int TICKS_W = 10;
    localparam int TICKS_MAX = 1023;
    localparam int UNIT_NUMERATOR_DEFAULT = 1200;
    localparam int DASH_UNITS = 3;

    // element codes as seen on the result word
    typedef enum logic [1:0] {
        EL_NONE = 2'd0,
        EL_DOT  = 2'd1,
        EL_DASH = 2'd2
    } element_t;

    // keyer phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_KEY  = 3'b010,
        PH_GAP  = 3'b100
    } phase_t;

    // timing settings handed from the register block to the core
    typedef struct packed {
        logic               mode_b;
        logic [TICKS_W-1:0] unit_ticks;
        logic [TICKS_W-1:0] dash_ticks;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic     key_down;
        element_t element;
        logic     element_started;
    } res_t;

    // saturate a tick count to the counter range
    function automatic logic [TICKS_W-1:0] sat_ticks(input int t);
        logic [TICKS_W-1:0] r;
        if (t > TICKS_MAX)
            r = TICKS_W'(TICKS_MAX);
        else
            r = TICKS_W'(t);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipk_if.sv =====
// Valid/ready channel interfaces for paddle words and keyer result words.
// Depends on nothing; payload widths are fixed by the field list.
`default_nettype none

interface ipk_paddle_if;
    logic valid;
    logic ready;
    logic dot_paddle;
    logic dash_paddle;

    modport source (output valid, output dot_paddle, output dash_paddle, input ready);
    modport sink   (input valid, input dot_paddle, input dash_paddle, output ready);
endinterface

interface ipk_key_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic [1:0] element;
    logic       element_started;

    modport source (output valid, output key_down, output element, output element_started,
                    input ready);
    modport sink   (input valid, input key_down, input element, input element_started,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ipk_cfg.sv =====
// Configuration registers: speed clamp, unit lookup and mode select.
// Depends on ipk_pkg; the unit table is built at elaboration.
`default_nettype none

module ipk_cfg #(
    parameter int UNIT_NUMERATOR = ipk_pkg::UNIT_NUMERATOR_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ipk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ipk_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ipk_pkg::cfg_t                         cfg
);
    import ipk_pkg::*;

    localparam int TabDepth = 2 ** CFG_DATA_W;
    localparam int ResetRaw = UNIT_NUMERATOR / int'(WPM_RESET);

    logic [TICKS_W-1:0] unit_tab [TabDepth];
    logic [TICKS_W-1:0] dash_tab [TabDepth];
    logic [CFG_DATA_W-1:0] wpm_clamped;
    logic                  mode_b_reg;
    logic [TICKS_W-1:0]    unit_reg;
    logic [TICKS_W-1:0]    dash_reg;

    // unit and dash lengths for every legal speed
    for (genvar g = 0; g < TabDepth; g++) begin : g_tab
        if (g >= int'(WPM_MIN) && g <= int'(WPM_MAX)) begin : g_legal
            localparam int Raw = UNIT_NUMERATOR / g;
            assign unit_tab[g] = sat_ticks(Raw);
            assign dash_tab[g] = sat_ticks(Raw * DASH_UNITS);
        end else begin : g_unused
            assign unit_tab[g] = '0;
            assign dash_tab[g] = '0;
        end
    end

    // clamp the written speed to the legal range
    always_comb
    begin
        if (cfg_data < WPM_MIN)
            wpm_clamped = WPM_MIN;
        else if (cfg_data > WPM_MAX)
            wpm_clamped = WPM_MAX;
        else
            wpm_clamped = cfg_data;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_b_reg <= 1'b0;
            unit_reg   <= sat_ticks(ResetRaw);
            dash_reg   <= sat_ticks(ResetRaw * DASH_UNITS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WPM:
                begin
                    unit_reg <= unit_tab[wpm_clamped];
                    dash_reg <= dash_tab[wpm_clamped];
                end
                REG_MODE_B:
                begin
                    mode_b_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.mode_b     = mode_b_reg;
    assign cfg.unit_ticks = unit_reg;
    assign cfg.dash_ticks = dash_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ipk_core.sv =====
// Keyer state: paddle latches, element choice and tick countdown.
// Depends on ipk_pkg; state advances once per accepted paddle word.
`default_nettype none

module ipk_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ipk_pkg::cfg_t      cfg,
    input  wire logic          accept,
    input  wire logic          dot_paddle,
    input  wire logic          dash_paddle,
    output ipk_pkg::res_t      res
);
    import ipk_pkg::*;

    phase_t             phase_reg, phase_next;
    element_t           cur_reg, cur_next;
    logic               last_dot_reg, last_dot_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic               dot_latch_reg, dot_latch_next;
    logic               dash_latch_reg, dash_latch_next;
    element_t           pick;
    logic               started;
    logic               keying;
    logic [TICKS_W-1:0] ticks_dec;

    always_comb
    begin
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        last_dot_next   = last_dot_reg;
        ticks_next      = ticks_reg;
        dot_latch_next  = dot_latch_reg;
        dash_latch_next = dash_latch_reg;
        started         = 1'b0;
        pick            = EL_NONE;
        ticks_dec       = '0;

        // catch presses; mode b only takes the opposite paddle while keying
        case (phase_reg)
            PH_KEY:
            begin
                if (cfg.mode_b)
                begin
                    if (cur_reg != EL_DOT && dot_paddle)
                        dot_latch_next = 1'b1;
                    if (cur_reg != EL_DASH && dash_paddle)
                        dash_latch_next = 1'b1;
                end
            end
            default:
            begin
                if (dot_paddle)
                    dot_latch_next = 1'b1;
                if (dash_paddle)
                    dash_latch_next = 1'b1;
            end
        endcase

        // choose the next element when idle, alternating on a squeeze
        if (phase_reg == PH_IDLE)
        begin
            if (dot_latch_next && dash_latch_next)
                pick = last_dot_reg ? EL_DASH : EL_DOT;
            else if (dot_latch_next)
                pick = EL_DOT;
            else if (dash_latch_next)
                pick = EL_DASH;

            if (pick != EL_NONE)
            begin
                if (!cfg.mode_b && dot_latch_next && dash_latch_next)
                begin
                    dot_latch_next  = 1'b0;
                    dash_latch_next = 1'b0;
                end
                else if (pick == EL_DOT)
                    dot_latch_next = 1'b0;
                else
                    dash_latch_next = 1'b0;

                started       = 1'b1;
                phase_next    = PH_KEY;
                cur_next      = pick;
                last_dot_next = (pick == EL_DOT);
                ticks_next    = (pick == EL_DASH) ? cfg.dash_ticks : cfg.unit_ticks;
            end
        end

        // result word for this tick
        keying              = (phase_next == PH_KEY);
        res.key_down        = keying;
        res.element         = keying ? cur_next : EL_NONE;
        res.element_started = started;

        // count down the element or gap
        if (phase_next == PH_KEY || phase_next == PH_GAP)
        begin
            ticks_dec  = (ticks_next != '0) ? ticks_next - TICKS_W'(1) : '0;
            ticks_next = ticks_dec;
            if (ticks_dec == '0)
            begin
                if (phase_next == PH_KEY)
                begin
                    phase_next = PH_GAP;
                    ticks_next = cfg.unit_ticks;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    cur_next   = EL_NONE;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cur_reg        <= EL_NONE;
            last_dot_reg   <= 1'b0;
            ticks_reg      <= '0;
            dot_latch_reg  <= 1'b0;
            dash_latch_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            cur_reg        <= cur_next;
            last_dot_reg   <= last_dot_next;
            ticks_reg      <= ticks_next;
            dot_latch_reg  <= dot_latch_next;
            dash_latch_reg <= dash_latch_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipk_outbuf.sv =====
// Result register with a skid slot, so a word is taken while one waits.
// Depends on ipk_pkg for the result word type.
`default_nettype none

module ipk_outbuf (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  ipk_pkg::res_t res,
    output logic          in_ready,
    ipk_key_if.source     keying
);
    import ipk_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic take;

    assign take     = main_valid_reg && keying.ready;
    assign in_ready = !skid_valid_reg;

    // slot valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            main_valid_reg <= skid_valid_reg || accept;
            skid_valid_reg <= skid_valid_reg && accept;
        end
        else if (accept)
        begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= main_valid_reg;
        end
    end

    // slot payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (accept)
                    skid_reg <= res;
            end
            else if (accept)
                main_reg <= res;
        end
        else if (accept)
        begin
            if (main_valid_reg)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

    assign keying.valid           = main_valid_reg;
    assign keying.key_down        = main_reg.key_down;
    assign keying.element         = main_reg.element;
    assign keying.element_started = main_reg.element_started;

endmodule

`default_nettype wire

// ===== hw/rtl/iambic_paddle_keyer_unit.sv =====
// Iambic paddle keyer, modes A and B, one paddle word per millisecond tick.
// Results are registered in the main slot, or in the skid slot while one waits.
// Throughput: one word per cycle unless the skid slot is full; the state update
// is a single pass of logic, and a two-slot result buffer keeps input flowing while a result waits.
// Reset: asynchronous, active low; keyer idle, latches clear, 20 wpm, mode A.
`default_nettype none

module iambic_paddle_keyer_unit #(
    parameter int UNIT_NUMERATOR = ipk_pkg::UNIT_NUMERATOR_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ipk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ipk_pkg::CFG_DATA_W-1:0]  cfg_data,
    ipk_paddle_if.sink                           paddles,
    ipk_key_if.source                            keying
);
    import ipk_pkg::*;

    cfg_t cfg;
    res_t res;
    logic accept;
    logic in_ready;

    assign paddles.ready = in_ready;
    assign accept        = paddles.valid && in_ready;

    // configuration registers
    ipk_cfg #(
        .UNIT_NUMERATOR (UNIT_NUMERATOR)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // keyer state machine
    ipk_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .dot_paddle  (paddles.dot_paddle),
        .dash_paddle (paddles.dash_paddle),
        .res         (res)
    );

    // result buffer
    ipk_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .res      (res),
        .in_ready (in_ready),
        .keying   (keying)
    );

    // a result word is valid on the next cycle after every taken paddle word
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> keying.valid)
        else $error("no result word after an accepted paddle word");

    // an element code only accompanies key down
    a_element_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        keying.valid && !keying.key_down |-> keying.element == EL_NONE)
        else $error("element reported with key up");

    // a start is always keyed
    a_start_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        keying.valid && keying.element_started |-> keying.key_down)
        else $error("element start without key down");

    // a key-down result never carries the none code
    a_keyed_has_element: assert property (@(posedge clk) disable iff (!rst_n)
        keying.valid && keying.key_down
            |-> (keying.element == EL_DOT || keying.element == EL_DASH))
        else $error("key down without a dot or dash");

endmodule

`default_nettype wire
